>>> rtl/hwpe_pkg.sv
// ----------------------------------------------------------------------------
// hwpe_pkg
// shared types and constants for the hex wireworld pulse engine
// ----------------------------------------------------------------------------
package hwpe_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_DEFAULT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_WIRE  = 2'd1,
    CELL_HEAD  = 2'd2,
    CELL_TAIL  = 2'd3
  } cell_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_STEP,
    ST_OUT
  } state_e;

  localparam int unsigned PeriodNum = 3 * 4095;
  localparam int unsigned PeriodMin = 3;
  localparam int unsigned WireRow   = 8;
  localparam int unsigned WireFirst = 2;
  localparam int unsigned WireLast  = 13;

  localparam logic [1:0] RegInjectCol = 2'd0;
  localparam logic [1:0] RegInjectRow = 2'd1;
  localparam logic [1:0] RegProbeCol  = 2'd2;
  localparam logic [1:0] RegProbeRow  = 2'd3;

  // command from the controller to every column cell
  typedef struct packed {
    logic step;     // advance one generation
    logic load_def; // reload default wire
    logic write;    // write the addressed cell
    logic inject;   // force head at inject cell
  } grid_cmd_t;

endpackage

>>> rtl/hwpe_column.sv
// ----------------------------------------------------------------------------
// hwpe_column
// one grid column: holds its cells and steps them using neighbour columns
// ----------------------------------------------------------------------------
module hwpe_column #(
  parameter int unsigned Rows = 16,
  parameter int unsigned Col  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hwpe_pkg::grid_cmd_t       cmd_i,
  input  logic [Rows-1:0]           wr_row_sel_i,
  input  logic [1:0]                wr_value_i,
  input  logic [Rows-1:0]           inj_row_sel_i,
  input  logic [Rows-1:0]           left_heads_i,
  input  logic [Rows-1:0]           right_heads_i,
  output logic [Rows-1:0]           heads_o,
  output logic [2*Rows-1:0]         cells_o
);
  import hwpe_pkg::*;

  logic [1:0] cell_q [Rows];
  logic [1:0] cell_d [Rows];

  // head bits as seen by the step, with the injected head already in place
  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      heads_o[r] = (cell_q[r] == CELL_HEAD) || (cmd_i.inject && inj_row_sel_i[r]);
      cells_o[2*r +: 2] = cell_q[r];
    end
  end

  always_comb begin
    logic [1:0] s;
    logic [2:0] n;
    logic       u0, u1, l0, l1, a, b;
    for (int r = 0; r < Rows; r++) begin
      s = cell_q[r];
      if (cmd_i.inject && inj_row_sel_i[r]) s = CELL_HEAD;
      cell_d[r] = cell_q[r];
      // side neighbours: even column rows r-1,r ; odd column rows r,r+1
      if ((Col % 2) == 0) begin
        u0 = (r > 0) ? left_heads_i[(r > 0) ? r-1 : 0] : 1'b0;
        u1 = left_heads_i[r];
        l0 = (r > 0) ? right_heads_i[(r > 0) ? r-1 : 0] : 1'b0;
        l1 = right_heads_i[r];
      end else begin
        u0 = left_heads_i[r];
        u1 = (r < Rows-1) ? left_heads_i[(r < Rows-1) ? r+1 : r] : 1'b0;
        l0 = right_heads_i[r];
        l1 = (r < Rows-1) ? right_heads_i[(r < Rows-1) ? r+1 : r] : 1'b0;
      end
      a = (r > 0) ? heads_o[(r > 0) ? r-1 : 0] : 1'b0;
      b = (r < Rows-1) ? heads_o[(r < Rows-1) ? r+1 : r] : 1'b0;
      n = 3'(u0) + 3'(u1) + 3'(l0) + 3'(l1) + 3'(a) + 3'(b);
      if (cmd_i.load_def) begin
        cell_d[r] = (r == WireRow && Col >= WireFirst && Col <= WireLast)
                    ? CELL_WIRE : CELL_EMPTY;
      end else if (cmd_i.write && wr_row_sel_i[r]) begin
        cell_d[r] = wr_value_i;
      end else if (cmd_i.step) begin
        case (s)
          CELL_EMPTY: cell_d[r] = CELL_EMPTY;
          CELL_HEAD:  cell_d[r] = CELL_TAIL;
          CELL_TAIL:  cell_d[r] = CELL_WIRE;
          default:    cell_d[r] = (n == 3'd1 || n == 3'd2) ? CELL_HEAD : CELL_WIRE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Rows; r++) begin
        cell_q[r] <= (r == WireRow && Col >= WireFirst && Col <= WireLast)
                     ? CELL_WIRE : CELL_EMPTY;
      end
    end else begin
      for (int r = 0; r < Rows; r++) cell_q[r] <= cell_d[r];
    end
  end

endmodule

>>> rtl/hwpe_divider.sv
// ----------------------------------------------------------------------------
// hwpe_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hwpe_divider #(
  parameter int unsigned Width = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);
  import hwpe_pkg::*;

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] quot_q, rem_q, div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [Width:0]   trial;

  assign trial  = {rem_q, quot_q[Width-1]} - {1'b0, div_q};
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      if (!trial[Width]) begin
        rem_q  <= trial[Width-1:0];
        quot_q <= {quot_q[Width-2:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[Width-2:0], quot_q[Width-1]};
        quot_q <= {quot_q[Width-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/hex_wireworld_pulse_engine_top.sv
// ----------------------------------------------------------------------------
// hex_wireworld_pulse_engine_top
// hex-grid wireworld automaton with sample-driven pulse injection
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command per transfer (tick, write, read, default
//   wire); m_axis returns exactly one result per command
//   a tick with a non-zero sample runs the period divide and then the
//   counter modulo on one shared restoring divider, then steps all
//   columns at once; every other command, and a tick with sample 0,
//   skips the divider and goes straight to the grid step
//   the grid is a row of column cells, each exchanging head bits with
//   its neighbouring columns every cycle
//   a result sits in an output register; the next command is taken only
//   once that result has been transferred, so a stalled receiver holds
//   the block
//   reset loads the default wire on row 8, clears the tick counter and
//   sets the registers to inject (2,8) and probe (13,8)
//   apb registers (word aligned): 0x0 inject_col, 0x4 inject_row, 0x8 probe_col, 0xc probe_row
// ----------------------------------------------------------------------------
module hex_wireworld_pulse_engine_top #(
  parameter int unsigned GRID_COLS = 16,
  parameter int unsigned GRID_ROWS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], sample[13:2], cell_col[17:14], cell_row[21:18], cell_value[23:22]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // head_out[0], pulse_injected[1], read_state[3:2], zero fill
  output logic [7:0]  m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hwpe_pkg::*;

  localparam int unsigned DivW = 64;

  state_e state_q, state_d;
  logic [3:0] inj_col_q, inj_row_q, prb_col_q, prb_row_q;
  logic [63:0] tick_q;
  logic [23:0] cmd_q;
  logic [7:0]  out_q;
  logic        out_valid_q;
  logic        pulse_q;
  logic        mod_zero_q;

  logic [1:0]  op;
  logic [11:0] sample;
  logic [3:0]  ccol, crow;
  assign op     = cmd_q[1:0];
  assign sample = cmd_q[13:2];
  assign ccol   = cmd_q[17:14];
  assign crow   = cmd_q[21:18];

  // apb
  logic apb_wr;
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegInjectCol: prdata[3:0] = inj_col_q;
      RegInjectRow: prdata[3:0] = inj_row_q;
      RegProbeCol:  prdata[3:0] = prb_col_q;
      default:      prdata[3:0] = prb_row_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_col_q <= 4'd2;
      inj_row_q <= 4'd8;
      prb_col_q <= 4'd13;
      prb_row_q <= 4'd8;
    end else if (apb_wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        RegInjectCol: inj_col_q <= pwdata[3:0];
        RegInjectRow: inj_row_q <= pwdata[3:0];
        RegProbeCol:  prb_col_q <= pwdata[3:0];
        default:      prb_row_q <= pwdata[3:0];
      endcase
    end
  end

  // shared divider: period then counter modulo
  logic            div_start, div_done;
  logic [DivW-1:0] div_a, div_b, div_quot, div_rem;
  logic [DivW-1:0] period;
  logic [15:0]     quot_clip;

  assign quot_clip = div_quot[15:0];
  assign period = (quot_clip < 16'(PeriodMin)) ? DivW'(PeriodMin) : DivW'(quot_clip);

  hwpe_divider #(.Width(DivW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_STEP;
      ST_STEP: begin
        if (op == OP_TICK && sample != '0 && !pulse_q) state_d = ST_DIV;
        else state_d = ST_OUT;
      end
      ST_DIV:  if (div_done) state_d = ST_MOD;
      ST_MOD:  if (div_done) state_d = ST_STEP;
      default: if (m_axis_tvalid && m_axis_tready) state_d = ST_IDLE;
    endcase
  end

  // divider start: period on entry, modulo after period
  logic step_first;
  assign step_first = (state_q == ST_STEP) && op == OP_TICK && sample != '0 && !pulse_q;
  always_comb begin
    div_start = 1'b0;
    div_a = DivW'(PeriodNum);
    div_b = DivW'(sample);
    if (step_first) begin
      div_start = 1'b1;
    end else if (state_q == ST_DIV && div_done) begin
      div_start = 1'b1;
      div_a = tick_q;
      div_b = period;
    end
  end

  // grid command, issued in ST_STEP once the pulse decision is known
  grid_cmd_t cmd;
  logic      inj_on, prb_on, do_step;
  assign inj_on  = (32'(inj_col_q) < GRID_COLS) && (32'(inj_row_q) < GRID_ROWS);
  assign prb_on  = (32'(prb_col_q) < GRID_COLS) && (32'(prb_row_q) < GRID_ROWS);
  assign do_step = (state_q == ST_STEP) && !step_first;
  // pulse only when the modulo came out zero and the inject cell is on the grid
  logic pulse_now;
  assign pulse_now = op == OP_TICK && pulse_q && mod_zero_q && inj_on;
  always_comb begin
    cmd = '0;
    if (do_step) begin
      cmd.step     = (op == OP_TICK);
      cmd.inject   = pulse_now;
      cmd.write    = (op == OP_WRITE);
      cmd.load_def = (op == OP_DEFAULT);
    end
  end

  // column chain
  logic [GRID_ROWS-1:0]   heads [GRID_COLS];
  logic [2*GRID_ROWS-1:0] cells [GRID_COLS];
  logic [GRID_ROWS-1:0]   wr_sel, inj_sel;
  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      wr_sel[r]  = (32'(crow) == r);
      inj_sel[r] = (32'(inj_row_q) == r);
    end
  end

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    logic [GRID_ROWS-1:0] lh, rh;
    if (c == 0) begin : g_l0
      assign lh = '0;
    end else begin : g_l
      assign lh = heads[c-1];
    end
    if (c == GRID_COLS-1) begin : g_rn
      assign rh = '0;
    end else begin : g_r
      assign rh = heads[c+1];
    end
    grid_cmd_t ccmd;
    always_comb begin
      ccmd = cmd;
      ccmd.write  = cmd.write && (32'(ccol) == c);
      ccmd.inject = cmd.inject && (32'(inj_col_q) == c);
    end
    hwpe_column #(.Rows(GRID_ROWS), .Col(c)) u_col (
      .clk_i, .rst_ni,
      .cmd_i(ccmd), .wr_row_sel_i(wr_sel), .wr_value_i(cmd_q[23:22]),
      .inj_row_sel_i(inj_sel), .left_heads_i(lh), .right_heads_i(rh),
      .heads_o(heads[c]), .cells_o(cells[c])
    );
  end

  // read and probe
  logic [1:0] rd_val, prb_val;
  always_comb begin
    rd_val = '0;
    prb_val = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        if (32'(ccol) == c && 32'(crow) == r) rd_val = cells[c][2*r +: 2];
        if (32'(prb_col_q) == c && 32'(prb_row_q) == r) prb_val = cells[c][2*r +: 2];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      pulse_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_axis_tvalid && s_axis_tready) begin
        pulse_q <= 1'b0;
        if (s_axis_tdata[1:0] == OP_TICK) tick_q <= tick_q + 64'd1;
      end
      // modulo done: marks the divide pass finished
      if (state_q == ST_MOD && div_done) pulse_q <= 1'b1;
      if (do_step) out_valid_q <= 1'b0;
      if (state_q == ST_OUT && !out_valid_q && state_d == ST_OUT) out_valid_q <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // capture the command, remember whether the modulo hit zero and fill the result
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) cmd_q <= s_axis_tdata;
    if (s_axis_tvalid && s_axis_tready) mod_zero_q <= 1'b0;
    else if (state_q == ST_MOD && div_done) mod_zero_q <= (div_rem == '0);
    if (do_step) out_q[1] <= pulse_now;
    if (state_q == ST_OUT && !out_valid_q) begin
      out_q[0]   <= (op == OP_TICK) && prb_on && (prb_val == CELL_HEAD);
      out_q[3:2] <= (op == OP_READ) ? rd_val : 2'b00;
      out_q[7:4] <= '0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q && state_q == ST_OUT;
  assign m_axis_tdata  = out_q;

  // a waiting result holds still until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

  // no new command while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid);

  // fill bits of the result stay zero
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0);

endmodule
